// ----- sv/qme_pkg.sv -----
// shared types and constants for the queue machine executor
package qme_pkg;
	localparam int QueueDepth = 1024;
	localparam int QAW = $clog2(QueueDepth);
	localparam int VB = 16;
	localparam int RegCount = 26;

	localparam logic [4:0] MD_PUSH = 5'd0;
	localparam logic [4:0] MD_ADD = 5'd1;
	localparam logic [4:0] MD_SUB = 5'd2;
	localparam logic [4:0] MD_MUL = 5'd3;
	localparam logic [4:0] MD_DIV = 5'd4;
	localparam logic [4:0] MD_MOD = 5'd5;
	localparam logic [4:0] MD_POPREG = 5'd6;
	localparam logic [4:0] MD_PUSHREG = 5'd7;
	localparam logic [4:0] MD_PRNUM_Q = 5'd8;
	localparam logic [4:0] MD_PRNUM_R = 5'd9;
	localparam logic [4:0] MD_PRCHR_Q = 5'd10;
	localparam logic [4:0] MD_PRCHR_R = 5'd11;
	localparam logic [4:0] MD_QUIT = 5'd12;
	localparam logic [4:0] MD_JMP = 5'd13;
	localparam logic [4:0] MD_JZ = 5'd14;
	localparam logic [4:0] MD_JEQ = 5'd15;
	localparam logic [4:0] MD_JGT = 5'd16;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_NUM = 2'd1;
	localparam logic [1:0] KIND_CHR = 2'd2;

	typedef struct packed {
		logic [4:0] mode;
		logic [15:0] immediate;
		logic [4:0] reg_first;
		logic [4:0] reg_second;
	} qme_in_t;

	typedef struct packed {
		logic [15:0] out_value;
		logic [1:0] out_kind;
		logic branch_taken;
		logic halted;
		logic fault;
	} qme_out_t;
endpackage

// ----- sv/qme_fifo.sv -----
// two-entry instruction queue between front end and back end
module qme_fifo (
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_stall,
	input qme_pkg::qme_in_t wr_data,
	output logic rd_valid,
	input logic rd_take,
	output qme_pkg::qme_in_t rd_data
);
	import qme_pkg::*;

	qme_in_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr_en;

	assign wr_stall = (cnt_q == 2'd2);
	assign wr_en = wr_valid && !wr_stall;
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_data;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en) wp_q <= ~wp_q;
			if (rd_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr_en} - {1'b0, rd_take};
		end
	end

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_take |-> rd_valid) else $error("queue read while empty");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("queue count out of range");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !rd_take) |=> wr_stall) else $error("full queue lost stall");
endmodule

// ----- sv/qme_divider.sv -----
// iterative restoring divider, one quotient bit per cycle
module qme_divider (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [15:0] dividend,
	input logic [15:0] divisor,
	output logic done,
	output logic [15:0] quotient,
	output logic [15:0] remainder
);
	import qme_pkg::*;

	logic [15:0] quo_q, den_q;
	logic [16:0] rem_q;
	logic [4:0] cnt_q;
	logic busy_q;
	logic [16:0] trial;
	logic [16:0] shifted;

	assign shifted = {rem_q[15:0], quo_q[15]};
	assign trial = shifted - {1'b0, den_q};
	assign done = busy_q && (cnt_q == 5'd0);
	assign quotient = quo_q;
	assign remainder = rem_q[15:0];

	// shift and subtract step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= 5'd0;
			quo_q <= '0;
			rem_q <= '0;
			den_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 5'd16;
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 5'd1;
				if (!trial[16]) begin
					rem_q <= trial;
					quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[14:0], 1'b0};
				end
			end
		end
	end
endmodule

// ----- sv/qme_back.sv -----
// back end: executes one instruction against queue store and registers
module qme_back (
	input logic clk,
	input logic arst_n,
	input logic ins_valid,
	output logic ins_take,
	input qme_pkg::qme_in_t ins,
	output logic res_valid,
	input logic res_stall,
	output qme_pkg::qme_out_t res
);
	import qme_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDX = 3'd1;
	localparam logic [2:0] ST_RDY = 3'd2;
	localparam logic [2:0] ST_CALC = 3'd3;
	localparam logic [2:0] ST_DIVW = 3'd4;
	localparam logic [2:0] ST_FIN = 3'd5;

	localparam logic [QAW:0] CNT_ONE = (QAW+1)'(1);
	localparam logic [QAW:0] CNT_TWO = (QAW+1)'(2);

	logic [VB-1:0] qmem [QueueDepth];
	logic [VB-1:0] regs_q [RegCount];
	logic [QAW-1:0] head_q, tail_q;
	logic [QAW:0] count_q;
	logic halt_q;
	logic [2:0] st_q;
	qme_in_t cur_q;
	logic [VB-1:0] rdata_q, x_q, y_q, r_q, ra_q, rb_q;
	logic out_v_q;
	qme_out_t out_q;
	qme_out_t fin_res;

	logic [QAW-1:0] rd_addr;
	logic full, free_out, start_div, div_done;
	logic [15:0] quo, rem;
	logic [31:0] prod;

	assign full = (count_q == QueueDepth[QAW:0]);
	assign free_out = !out_v_q || !res_stall;
	assign ins_take = ins_valid && st_q == ST_IDLE && free_out;
	assign res_valid = out_v_q;
	assign res = out_q;
	assign start_div = (st_q == ST_CALC) &&
		(cur_q.mode == MD_DIV || cur_q.mode == MD_MOD) && (y_q != '0);
	assign prod = {16'd0, x_q} * {16'd0, y_q};

	function automatic logic [QAW-1:0] nxt(input logic [QAW-1:0] p);
		nxt = (p == QAW'(QueueDepth - 1)) ? '0 : p + QAW'(1);
	endfunction

	function automatic logic [VB-1:0] rget(input logic [VB-1:0] rf [RegCount],
		input logic [4:0] i);
		rget = (i < 5'(RegCount)) ? rf[i] : '0;
	endfunction

	assign rd_addr = (st_q == ST_RDX) ? nxt(head_q) : head_q;

	qme_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(start_div), .dividend(x_q),
		.divisor(y_q), .done(div_done), .quotient(quo), .remainder(rem)
	);

	// queue memory write and registered read
	logic mem_we;
	logic [VB-1:0] mem_wd;
	always_ff @(posedge clk) begin
		if (mem_we) qmem[tail_q] <= mem_wd;
		rdata_q <= qmem[rd_addr];
	end

	// decode write of queue memory
	always_comb begin
		mem_we = 1'b0;
		mem_wd = r_q;
		if (st_q == ST_FIN && !halt_q) begin
			if (cur_q.mode == MD_PUSH && !full) begin
				mem_we = 1'b1;
				mem_wd = cur_q.immediate;
			end else if (cur_q.mode == MD_PUSHREG && !full) begin
				mem_we = 1'b1;
				mem_wd = ra_q;
			end else if (cur_q.mode >= MD_ADD && cur_q.mode <= MD_MOD &&
				count_q >= CNT_TWO) begin
				mem_we = 1'b1;
			end
		end
	end

	// result transaction of the finishing instruction
	always_comb begin
		fin_res = '0;
		if (halt_q) begin
			fin_res.halted = 1'b1;
		end else begin
			fin_res.halted = (cur_q.mode == MD_QUIT);
			case (cur_q.mode)
				MD_PUSH, MD_PUSHREG: fin_res.fault = full;
				MD_ADD, MD_SUB, MD_MUL, MD_DIV, MD_MOD: fin_res.fault = (count_q < CNT_TWO);
				MD_POPREG: fin_res.fault = (count_q == '0);
				MD_PRNUM_Q: begin
					if (count_q == '0) fin_res.fault = 1'b1;
					else begin
						fin_res.out_value = x_q;
						fin_res.out_kind = KIND_NUM;
					end
				end
				MD_PRCHR_Q: begin
					if (count_q == '0) fin_res.fault = 1'b1;
					else begin
						fin_res.out_value = {8'd0, x_q[7:0]};
						fin_res.out_kind = KIND_CHR;
					end
				end
				MD_PRNUM_R: begin
					fin_res.out_value = ra_q;
					fin_res.out_kind = KIND_NUM;
				end
				MD_PRCHR_R: begin
					fin_res.out_value = {8'd0, ra_q[7:0]};
					fin_res.out_kind = KIND_CHR;
				end
				MD_JMP: fin_res.branch_taken = 1'b1;
				MD_JZ: fin_res.branch_taken = (ra_q == '0);
				MD_JEQ: fin_res.branch_taken = (ra_q == rb_q);
				MD_JGT: fin_res.branch_taken = (ra_q > rb_q);
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			halt_q <= 1'b0;
			out_v_q <= 1'b0;
			for (int i = 0; i < RegCount; i++) regs_q[i] <= '0;
		end else begin
			if (st_q == ST_FIN) out_v_q <= 1'b1;
			else if (!res_stall) out_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (ins_take) begin
						cur_q <= ins;
						ra_q <= rget(regs_q, ins.reg_first);
						rb_q <= rget(regs_q, ins.reg_second);
						st_q <= ST_RDX;
					end
				end
				ST_RDX: begin
					x_q <= rdata_q;
					st_q <= (cur_q.mode >= MD_ADD && cur_q.mode <= MD_MOD) ? ST_RDY : ST_FIN;
				end
				ST_RDY: begin
					y_q <= rdata_q;
					st_q <= ST_CALC;
				end
				ST_CALC: begin
					case (cur_q.mode)
						MD_ADD: r_q <= x_q + y_q;
						MD_SUB: r_q <= x_q - y_q;
						MD_MUL: r_q <= prod[15:0];
						default: r_q <= '0;
					endcase
					st_q <= start_div ? ST_DIVW : ST_FIN;
				end
				ST_DIVW: begin
					if (div_done) begin
						r_q <= (cur_q.mode == MD_DIV) ? quo : rem;
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					out_q <= fin_res;
					st_q <= ST_IDLE;
					if (!halt_q) begin
						case (cur_q.mode)
							MD_PUSH, MD_PUSHREG: begin
								if (!full) begin
									tail_q <= nxt(tail_q);
									count_q <= count_q + CNT_ONE;
								end
							end
							MD_ADD, MD_SUB, MD_MUL, MD_DIV, MD_MOD: begin
								if (count_q >= CNT_TWO) begin
									head_q <= nxt(nxt(head_q));
									tail_q <= nxt(tail_q);
									count_q <= count_q - CNT_ONE;
								end
							end
							MD_POPREG, MD_PRNUM_Q, MD_PRCHR_Q: begin
								if (count_q != '0) begin
									head_q <= nxt(head_q);
									count_q <= count_q - CNT_ONE;
									if (cur_q.mode == MD_POPREG &&
										cur_q.reg_first < 5'(RegCount))
										regs_q[cur_q.reg_first] <= x_q;
								end
							end
							MD_QUIT: halt_q <= 1'b1;
							default: ;
						endcase
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QueueDepth[QAW:0]) else $error("queue count overflow");
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q) else $error("halt flag cleared");
	a_halt_out: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.halted) |-> (res.out_kind == KIND_NONE && !res.fault))
		else $error("halted result carries data");
endmodule

// ----- sv/queue_machine_executor_unit.sv -----
// top level of the queue machine executor
// sequencing: idle, first queue read and finish for most instructions; add/sub/mul
//   and division by zero add a second read and a calculate step, and div/mod with a
//   nonzero divisor also waits on the 16-step divider
// issue: the back end takes a new instruction only when idle; it reads the queue memory before writing it
// reset: arst_n clears registers, queue pointers, halt flag and queues;
//   queue memory contents stay undefined until written
module queue_machine_executor_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input qme_pkg::qme_in_t in_data,
	output logic out_valid,
	input logic out_stall,
	output qme_pkg::qme_out_t out_data
);
	import qme_pkg::*;

	logic q_valid, q_take;
	qme_in_t q_data;

	// front end: instruction queue
	qme_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(in_valid), .wr_stall(in_stall),
		.wr_data(in_data), .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_data)
	);

	// back end: execution
	qme_back u_back (
		.clk(clk), .arst_n(arst_n), .ins_valid(q_valid), .ins_take(q_take),
		.ins(q_data), .res_valid(out_valid), .res_stall(out_stall), .res(out_data)
	);
endmodule
